// ----- rtl/core/gpe_pkg.sv -----
// Shared types and constants for the GPIO port with edge interrupts.
// Holds the transfer payload structs and the op and register index codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpe_pkg;

    localparam int unsigned PinCountDefault = 16;
    localparam int unsigned PortWidth       = 16;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SAMPLE = 2'd2
    } t_gpe_op;

    typedef enum logic [3:0] {
        REG_MODE     = 4'd0,
        REG_OTYPE    = 4'd1,
        REG_SPEED    = 4'd2,
        REG_PULL     = 4'd3,
        REG_INPUT    = 4'd4,
        REG_OUTPUT   = 4'd5,
        REG_SETRESET = 4'd6,
        REG_ALT_LO   = 4'd7,
        REG_ALT_HI   = 4'd8,
        REG_IMASK    = 4'd9,
        REG_RISE     = 4'd10,
        REG_FALL     = 4'd11,
        REG_PENDING  = 4'd12
    } t_gpe_reg;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } t_gpe_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic [15:0] output_enable;
        logic        irq;
    } t_gpe_rsp;

endpackage

`default_nettype wire

// ----- rtl/core/gpe_stream_if.sv -----
// Valid/ready stream interface used for request and response transfers.
// Payload type is a parameter; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

interface gpe_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gpio_port_edge_interrupt.sv -----
// Top level of the GPIO port with edge interrupts: register file, sample logic,
// response register. Depends on gpe_pkg and gpe_stream_if.
`timescale 1ns / 1ps
`default_nettype none

// One GPIO port of up to 16 pins, driven by a request stream. Each request is a
// register read, a register write or a pin sample tick, and each produces exactly
// one response carrying the read data (zero unless a read), the output data
// levels, the output enables (pins whose mode field is 01) and the interrupt line
// (any pending bit that is also unmasked), all as seen after the request.
// Throughput is one request per clock while o_out is not stalled: the register
// file updates at the edge that takes the request and the response lands in a
// single output register at that same edge, valid from the next cycle. That output
// register also decouples the sides: a new request is taken whenever the register
// is empty or being drained in that cycle. Set/reset writes set from the low half
// and clear from the high half, set winning; pending is write-one-to-clear; a
// sample latches the pins and flags pending on the selected rising and falling
// edges. Bits of pins at or above PIN_COUNT always read zero.
module gpio_port_edge_interrupt
    import gpe_pkg::*;
#(
    parameter int unsigned PIN_COUNT = PinCountDefault
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    gpe_stream_if.sink   i_in,
    gpe_stream_if.source o_out
);

    // Masks of the implemented pins, per register layout
    localparam int unsigned AltCntLo = (PIN_COUNT > 8) ? 8 : PIN_COUNT;
    localparam int unsigned AltCntHi = (PIN_COUNT > 8) ? (PIN_COUNT - 8) : 0;
    localparam logic [15:0] PinMask  = 16'((64'd1 << PIN_COUNT) - 64'd1);
    localparam logic [31:0] PairMask = 32'((64'd1 << (2 * PIN_COUNT)) - 64'd1);
    localparam logic [31:0] AltMaskLo = 32'((64'd1 << (4 * AltCntLo)) - 64'd1);
    localparam logic [31:0] AltMaskHi = 32'((64'd1 << (4 * AltCntHi)) - 64'd1);

    // Port registers
    logic [31:0] r_mode,    n_mode;
    logic [15:0] r_otype,   n_otype;
    logic [31:0] r_speed,   n_speed;
    logic [31:0] r_pull,    n_pull;
    logic [15:0] r_input,   n_input;
    logic [15:0] r_output,  n_output;
    logic [31:0] r_alt_lo,  n_alt_lo;
    logic [31:0] r_alt_hi,  n_alt_hi;
    logic [15:0] r_imask,   n_imask;
    logic [15:0] r_rise,    n_rise;
    logic [15:0] r_fall,    n_fall;
    logic [15:0] r_pending, n_pending;

    // Response register
    t_gpe_rsp r_out, n_out;
    logic     r_out_valid;

    logic        in_xfer;
    logic [31:0] rd_data;
    logic [15:0] pins;
    logic [15:0] oe;
    t_gpe_req    req;

    assign req      = i_in.data;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign pins     = req.pin_levels & PinMask;

    // Register update and read mux
    always_comb begin
        n_mode    = r_mode;
        n_otype   = r_otype;
        n_speed   = r_speed;
        n_pull    = r_pull;
        n_input   = r_input;
        n_output  = r_output;
        n_alt_lo  = r_alt_lo;
        n_alt_hi  = r_alt_hi;
        n_imask   = r_imask;
        n_rise    = r_rise;
        n_fall    = r_fall;
        n_pending = r_pending;
        rd_data   = '0;
        if (in_xfer) begin
            unique case (t_gpe_op'(req.op))
                OP_READ: begin
                    unique case (t_gpe_reg'(req.reg_index))
                        REG_MODE:    rd_data = r_mode;
                        REG_OTYPE:   rd_data = {16'd0, r_otype};
                        REG_SPEED:   rd_data = r_speed;
                        REG_PULL:    rd_data = r_pull;
                        REG_INPUT:   rd_data = {16'd0, r_input};
                        REG_OUTPUT:  rd_data = {16'd0, r_output};
                        REG_ALT_LO:  rd_data = r_alt_lo;
                        REG_ALT_HI:  rd_data = r_alt_hi;
                        REG_IMASK:   rd_data = {16'd0, r_imask};
                        REG_RISE:    rd_data = {16'd0, r_rise};
                        REG_FALL:    rd_data = {16'd0, r_fall};
                        REG_PENDING: rd_data = {16'd0, r_pending};
                        default:     rd_data = '0;  // set/reset and unused slots
                    endcase
                end
                OP_WRITE: begin
                    unique case (t_gpe_reg'(req.reg_index))
                        REG_MODE:   n_mode   = req.write_data & PairMask;
                        REG_OTYPE:  n_otype  = req.write_data[15:0] & PinMask;
                        REG_SPEED:  n_speed  = req.write_data & PairMask;
                        REG_PULL:   n_pull   = req.write_data & PairMask;
                        REG_OUTPUT: n_output = req.write_data[15:0] & PinMask;
                        REG_SETRESET: begin
                            // set half wins over reset half
                            n_output = ((r_output & ~req.write_data[31:16])
                                        | req.write_data[15:0]) & PinMask;
                        end
                        REG_ALT_LO:  n_alt_lo  = req.write_data & AltMaskLo;
                        REG_ALT_HI:  n_alt_hi  = req.write_data & AltMaskHi;
                        REG_IMASK:   n_imask   = req.write_data[15:0] & PinMask;
                        REG_RISE:    n_rise    = req.write_data[15:0] & PinMask;
                        REG_FALL:    n_fall    = req.write_data[15:0] & PinMask;
                        REG_PENDING: n_pending = r_pending & ~req.write_data[15:0] & PinMask;
                        default: ;  // input data is read-only, unused slots ignored
                    endcase
                end
                OP_SAMPLE: begin
                    n_pending = (r_pending | (~r_input & pins & r_rise)
                                 | (r_input & ~pins & r_fall)) & PinMask;
                    n_input   = pins;
                end
                default: ;
            endcase
        end
    end

    // Output enables follow the post-update mode field
    always_comb begin
        for (int i = 0; i < PortWidth; i++) begin
            oe[i] = (n_mode[2*i +: 2] == 2'b01) && PinMask[i];
        end
    end

    always_comb begin
        n_out.read_data     = rd_data;
        n_out.pin_drive     = n_output;
        n_out.output_enable = oe;
        n_out.irq           = |(n_pending & n_imask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= '0;
            r_otype   <= '0;
            r_speed   <= '0;
            r_pull    <= '0;
            r_input   <= '0;
            r_output  <= '0;
            r_alt_lo  <= '0;
            r_alt_hi  <= '0;
            r_imask   <= '0;
            r_rise    <= '0;
            r_fall    <= '0;
            r_pending <= '0;
        end else begin
            r_mode    <= n_mode;
            r_otype   <= n_otype;
            r_speed   <= n_speed;
            r_pull    <= n_pull;
            r_input   <= n_input;
            r_output  <= n_output;
            r_alt_lo  <= n_alt_lo;
            r_alt_hi  <= n_alt_hi;
            r_imask   <= n_imask;
            r_rise    <= n_rise;
            r_fall    <= n_fall;
            r_pending <= n_pending;
        end
    end

    // Response register: loaded on every request transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Checks
    a_pending_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending & ~PinMask) == 16'd0)
        else $error("pending bit set on an unimplemented pin");

    a_irq_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (o_out.data.irq == |(r_pending & r_imask)))
        else $error("irq in response disagrees with register state");

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && req.op != OP_READ) |=> (o_out.data.read_data == 32'd0))
        else $error("non-read response carries read data");

    a_set_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && req.op == OP_WRITE && req.reg_index == REG_SETRESET)
        |=> ((r_output & $past(req.write_data[15:0] & PinMask))
             == $past(req.write_data[15:0] & PinMask)))
        else $error("set/reset write failed to set a requested pin");

    a_sample_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && req.op == OP_SAMPLE) |=> (r_input == $past(pins)))
        else $error("sample did not latch pin levels");

endmodule

`default_nettype wire
